FILE: hdl/bitmap_row_shear_assert.svh
// Assertion macros for the row shear block.
`ifndef BITMAP_ROW_SHEAR_ASSERT_SVH
`define BITMAP_ROW_SHEAR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Types and constants shared by the row shear block and its step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_OLD_ROW_BYTES = 2'd0;
   localparam logic [1:0] CSR_NEW_ROW_BYTES = 2'd1;
   localparam logic [1:0] CSR_ROWS_PER_STEP = 2'd2;

   localparam logic [10:0] ROW_BYTES_MAX  = 11'd1024;
   localparam logic [9:0]  BYTE_SHIFT_MAX = 10'd1023;
   localparam logic [7:0]  WHITE_BYTE     = 8'hFF;

   localparam logic [10:0] OLD_ROW_BYTES_RST = 11'd4;
   localparam logic [10:0] NEW_ROW_BYTES_RST = 11'd8;
   localparam logic [15:0] ROWS_PER_STEP_RST = 16'd2048;
   localparam logic [15:0] COUNTDOWN_RST     = 16'd1024;

   typedef struct packed {
      logic [10:0] old_row_bytes;
      logic [10:0] new_row_bytes;
      logic [15:0] rows_per_step;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  bit_shift;
      logic [9:0]  byte_shift;
      logic [15:0] step_countdown;
      logic [9:0]  in_position;
      logic [9:0]  out_position;
      logic [7:0]  carry_byte;
   } shear_state_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [10:0] repeat_count;
      logic        row_end;
      logic        last;
   } result_type;

   // Slot 0 fill run, slot 1 data word, slot 2 white tail
   typedef struct packed {
      logic [2:0]       vld;
      result_type [2:0] res;
   } bundle_type;

endpackage

`default_nettype wire

FILE: hdl/brs_step.sv
// ----------------------------------------------------------------------------
// brs_step
// Per-word shear logic: from the current state and one input word, works out
// the next state and the up to three results the word gives.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_step (
   input  brs_pkg::cfg_type         cfg,
   input  brs_pkg::shear_state_type state_cur,
   input  logic [7:0]               pixel_byte,
   output brs_pkg::shear_state_type state_nxt,
   output brs_pkg::bundle_type      bundle
);
   import brs_pkg::*;

   logic [10:0] width;
   logic [10:0] old_w;
   logic        row_start;
   logic [7:0]  carry0;
   logic [15:0] shifted;
   logic [10:0] fill_cnt;
   logic [10:0] op1;
   logic [10:0] op2;
   logic [10:0] tail_cnt;
   logic        last_in;
   logic        data_vld;
   logic [7:0]  data_byte;
   logic [15:0] cd_dec;

   always_comb begin
      // Clamp row widths into the supported range
      width = cfg.new_row_bytes;
      if (width < 11'd2) width = 11'd2;
      if (width > ROW_BYTES_MAX) width = ROW_BYTES_MAX;
      old_w = cfg.old_row_bytes;
      if (old_w < 11'd1) old_w = 11'd1;
      if (old_w > ROW_BYTES_MAX) old_w = ROW_BYTES_MAX;

      row_start = (state_cur.in_position == 10'd0);
      carry0    = row_start ? ~(WHITE_BYTE >> state_cur.bit_shift) : state_cur.carry_byte;
      shifted   = {pixel_byte, 8'h00} >> state_cur.bit_shift;

      // Leading fill, clipped to the row
      fill_cnt = 11'd0;
      if (row_start) begin
         fill_cnt = ({1'b0, state_cur.byte_shift} < width) ?
                    {1'b0, state_cur.byte_shift} : width;
      end
      op1 = {1'b0, state_cur.out_position} + fill_cnt;

      last_in = ({1'b0, state_cur.in_position} + 11'd1) >= old_w;

      // Data word: merged pixels, or the closing partial word at row end
      if (!last_in) begin
         data_vld  = (op1 + 11'd2) < width;
         data_byte = carry0 | shifted[15:8];
      end else begin
         data_vld  = (op1 + 11'd1) < width;
         data_byte = carry0 | (WHITE_BYTE >> state_cur.bit_shift);
      end
      op2 = op1 + {10'd0, data_vld};

      // White tail up to the row end
      tail_cnt = 11'd0;
      if (last_in && (op2 < width)) tail_cnt = width - op2;

      bundle.vld[0] = (fill_cnt != 11'd0);
      bundle.vld[1] = data_vld;
      bundle.vld[2] = (tail_cnt != 11'd0);

      bundle.res[0].out_byte     = WHITE_BYTE;
      bundle.res[0].repeat_count = fill_cnt;
      bundle.res[0].row_end      = (op1 >= width);
      bundle.res[0].last         = !data_vld && (tail_cnt == 11'd0);

      bundle.res[1].out_byte     = data_byte;
      bundle.res[1].repeat_count = 11'd1;
      bundle.res[1].row_end      = (op2 >= width);
      bundle.res[1].last         = (tail_cnt == 11'd0);

      bundle.res[2].out_byte     = WHITE_BYTE;
      bundle.res[2].repeat_count = tail_cnt;
      bundle.res[2].row_end      = 1'b1;
      bundle.res[2].last         = 1'b1;

      // Advance the row and shift state
      state_nxt = state_cur;
      cd_dec    = state_cur.step_countdown - 16'd1;
      if (!last_in) begin
         state_nxt.in_position  = state_cur.in_position + 10'd1;
         state_nxt.out_position = op2[9:0];
         state_nxt.carry_byte   = data_vld ? shifted[7:0] : carry0;
      end else begin
         state_nxt.in_position    = 10'd0;
         state_nxt.out_position   = 10'd0;
         state_nxt.carry_byte     = carry0;
         state_nxt.step_countdown = cd_dec;
         if (cd_dec == 16'd0) begin
            state_nxt.step_countdown = (cfg.rows_per_step == 16'd0) ? 16'd1 :
                                       cfg.rows_per_step;
            state_nxt.bit_shift = state_cur.bit_shift + 3'd1;
            if ((state_cur.bit_shift == 3'd7) &&
                (state_cur.byte_shift != BYTE_SHIFT_MAX)) begin
               state_nxt.byte_shift = state_cur.byte_shift + 10'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bitmap_row_shear.sv
// ----------------------------------------------------------------------------
// bitmap_row_shear
// Streaming horizontal shear of a one-bit-per-pixel image, fill runs coded
// as a single word with a repeat count.
// ----------------------------------------------------------------------------
// An input word is worked out in the cycle it is accepted and its up to
// three results (fill run, shifted data word, white tail) land in a
// three-slot hold register; they leave through a registered output stage one
// per cycle while the output does not stall. A word that gives one result
// lets the block take one word per cycle on the same terms; a word that gives
// more occupies the single output port one result at a time, and the next
// word is taken in the cycle the last of them moves to the output stage. A
// word that gives no result does not hold up the next word. Configuration
// writes take effect at once and are meant for idle periods only.
`default_nettype none

module bitmap_row_shear (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [10:0] rsp_repeat_count,
   output logic        rsp_row_end,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import brs_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   shear_state_type state_ff, state_in, state_nxt;
   bundle_type      bundle;
   logic [2:0]       pend_vld_ff, pend_vld_in, pend_vld_left;
   result_type [2:0] pend_res_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   result_type       rsp_res_ff, rsp_res_in;
   logic             out_free;
   logic             move;
   logic [2:0]       pop_sel;
   result_type       pop_res;
   logic             accept;

   brs_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .pixel_byte (req_pixel_byte),
      .state_nxt  (state_nxt),
      .bundle     (bundle)
   );

   // Pick the oldest held result for the output stage
   always_comb begin
      out_free = !rsp_vld_ff || rsp_ready;
      move     = out_free && (pend_vld_ff != 3'b000);
      pop_sel  = 3'b000;
      pop_res  = pend_res_ff[2];
      if (pend_vld_ff[0]) begin
         pop_sel = 3'b001;
         pop_res = pend_res_ff[0];
      end else if (pend_vld_ff[1]) begin
         pop_sel = 3'b010;
         pop_res = pend_res_ff[1];
      end else if (pend_vld_ff[2]) begin
         pop_sel = 3'b100;
      end
      pend_vld_left = pend_vld_ff & ~(move ? pop_sel : 3'b000);
      req_ready     = (pend_vld_left == 3'b000);
      accept        = req_valid && req_ready;
      pend_vld_in   = accept ? bundle.vld : pend_vld_left;
   end

   // Output stage: load on a move, drop once taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_res_in = rsp_res_ff;
      if (move) begin
         rsp_vld_in = 1'b1;
         rsp_res_in = pop_res;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Configuration writes and state advance
   always_comb begin
      cfg_in   = cfg_ff;
      state_in = accept ? state_nxt : state_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OLD_ROW_BYTES: cfg_in.old_row_bytes = csr_wdata[10:0];
            CSR_NEW_ROW_BYTES: cfg_in.new_row_bytes = csr_wdata[10:0];
            CSR_ROWS_PER_STEP: begin
               cfg_in.rows_per_step     = csr_wdata;
               state_in.step_countdown  = (csr_wdata[15:1] == 15'd0) ? 16'd1 :
                                          {1'b0, csr_wdata[15:1]};
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.old_row_bytes    <= OLD_ROW_BYTES_RST;
         cfg_ff.new_row_bytes    <= NEW_ROW_BYTES_RST;
         cfg_ff.rows_per_step    <= ROWS_PER_STEP_RST;
         state_ff.bit_shift      <= 3'd0;
         state_ff.byte_shift     <= 10'd0;
         state_ff.step_countdown <= COUNTDOWN_RST;
         state_ff.in_position    <= 10'd0;
         state_ff.out_position   <= 10'd0;
         state_ff.carry_byte     <= 8'd0;
         pend_vld_ff             <= 3'b000;
         rsp_vld_ff              <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Hold payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) pend_res_ff <= bundle.res;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_out_byte     = rsp_res_ff.out_byte;
   assign rsp_repeat_count = rsp_res_ff.repeat_count;
   assign rsp_row_end      = rsp_res_ff.row_end;
   assign rsp_last         = rsp_res_ff.last;

endmodule

`default_nettype wire

FILE: hdl/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks on the result channel of the row shear block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_row_shear_assert.svh"

module brs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic [10:0] rsp_repeat_count,
   input  logic        rsp_row_end,
   input  logic        rsp_last
);

   // A result always stands for at least one word
   `BRS_ASSERT_NOW(a_count_nonzero, rsp_valid, rsp_repeat_count != 11'd0, "zero repeat count")

   // Only white fill runs repeat
   `BRS_ASSERT_NOW(a_run_is_white, rsp_valid && (rsp_repeat_count > 11'd1), rsp_out_byte == 8'hFF, "non-white run")

   // Nothing of a word follows the end of its output row
   `BRS_ASSERT_NOW(a_row_end_last, rsp_valid && rsp_row_end, rsp_last, "row end before last result")

   // Hold a stalled result
   `BRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_repeat_count) && $stable(rsp_row_end) && $stable(rsp_last), "stalled result changed")

endmodule

bind bitmap_row_shear brs_checker u_brs_checker (.*);

`default_nettype wire
